// ===== hdl/mmch_pkg.sv =====
// ----------------------------------------------------------------------------
// mmch_pkg
// Shared types and constants of the minimum merge cost heap core.
// ----------------------------------------------------------------------------
package mmch_pkg;

  // default configuration
  localparam int unsigned MAX_ITEMS_DEF    = 1024;
  localparam int unsigned ADDEND_WIDTH_DEF = 32;

  // width of heap entries, sums and the cost
  localparam int unsigned DATA_W = 64;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP,
    ST_UP_CMP,
    ST_CHK,
    ST_TAKE,
    ST_TOP,
    ST_LAST,
    ST_DN,
    ST_DN_L,
    ST_DN_R,
    ST_OUT
  } state_e;

endpackage

// ===== hdl/mmch_heap_ram.sv =====
// ----------------------------------------------------------------------------
// mmch_heap_ram
// Heap storage: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mmch_heap_ram #(
  parameter int unsigned DEPTH = mmch_pkg::MAX_ITEMS_DEF,
  parameter int unsigned AW    = $clog2(mmch_pkg::MAX_ITEMS_DEF)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [mmch_pkg::DATA_W-1:0] wr_data_i,
  input  logic [AW-1:0]               rd_addr_i,
  output logic [mmch_pkg::DATA_W-1:0] rd_data_o
);

  logic [mmch_pkg::DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

// ===== hdl/min_merge_cost_heap_core.sv =====
// ----------------------------------------------------------------------------
// min_merge_cost_heap_core
// Optimal (Huffman) merge cost of a set of addends, built on a min-heap memory.
// ----------------------------------------------------------------------------
// Addends arrive one item at a time; last_item closes the set. Each addend is
// inserted into a min-heap held in a memory with one read and one write port,
// and a small sequencer runs every heap step through that port pair with one
// compare unit. An insert climbs level by level (ST_UP, ST_UP_CMP) until it
// reaches the root or stops below a parent that is not larger; the block is
// not ready while it runs, so a new item is taken only once the last insert
// is done. After the last item each merge step takes two minima (ST_TAKE,
// ST_TOP, ST_LAST, then a sift-down and a write of the moved entry) and
// inserts their sum, and the heap is merged down to one value before the
// result item is issued.
// Heap entries are never cleared: only entries below the fill count are read.
// Addends beyond MAX_ITEMS are dropped and flagged through overflow_o. A new
// set may be accepted while the previous result waits on the output.
// ----------------------------------------------------------------------------
module min_merge_cost_heap_core #(
  parameter int unsigned MAX_ITEMS    = mmch_pkg::MAX_ITEMS_DEF,
  parameter int unsigned ADDEND_WIDTH = mmch_pkg::ADDEND_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ADDEND_WIDTH-1:0]     addend_i,
  input  logic                        last_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mmch_pkg::DATA_W-1:0] total_cost_o,
  output logic                        overflow_o
);

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned SW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned CW = AW + 2;
  localparam int unsigned DW = mmch_pkg::DATA_W;

  mmch_pkg::state_e state_q, state_d;

  logic [SW-1:0] size_q, size_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [DW-1:0] cur_q, cur_d;
  logic [DW-1:0] child_q, child_d;
  logic [DW-1:0] top_q, top_d;
  logic [DW-1:0] first_q, first_d;
  logic [DW-1:0] cost_q, cost_d;
  logic          second_q, second_d;
  logic          merge_q, merge_d;
  logic          last_q, last_d;
  logic          ovf_q, ovf_d;
  logic          out_valid_q, out_valid_d;
  logic [DW-1:0] total_cost_q, total_cost_d;
  logic          overflow_q, overflow_d;

  // memory port signals
  logic          ram_we;
  logic [AW-1:0] ram_wr_addr;
  logic [DW-1:0] ram_wr_data;
  logic [AW-1:0] ram_rd_addr;
  logic [DW-1:0] ram_rd_data;

  // index arithmetic
  logic [AW-1:0] parent;
  logic [CW-1:0] left_w, right_w, size_w;
  logic [DW-1:0] min_child, pair_sum;
  logic [AW-1:0] min_idx;
  logic          ins_done, dn_done;

  assign parent  = (pos_q - AW'(1)) >> 1;
  assign left_w  = CW'({pos_q, 1'b1});
  assign right_w = left_w + CW'(1);
  assign size_w  = CW'(size_q);
  assign pair_sum = first_q + top_q;

  mmch_heap_ram #(
    .DEPTH (MAX_ITEMS),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mmch_pkg::ST_IDLE;
      size_q      <= '0;
      cost_q      <= '0;
      ovf_q       <= 1'b0;
      second_q    <= 1'b0;
      merge_q     <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      cost_q      <= cost_d;
      ovf_q       <= ovf_d;
      second_q    <= second_d;
      merge_q     <= merge_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    cur_q        <= cur_d;
    child_q      <= child_d;
    top_q        <= top_d;
    first_q      <= first_d;
    total_cost_q <= total_cost_d;
    overflow_q   <= overflow_d;
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    size_d       = size_q;
    pos_d        = pos_q;
    cur_d        = cur_q;
    child_d      = child_q;
    top_d        = top_q;
    first_d      = first_q;
    cost_d       = cost_q;
    second_d     = second_q;
    merge_d      = merge_q;
    last_d       = last_q;
    ovf_d        = ovf_q;
    total_cost_d = total_cost_q;
    overflow_d   = overflow_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    ram_we       = 1'b0;
    ram_wr_addr  = pos_q;
    ram_wr_data  = cur_q;
    ram_rd_addr  = '0;
    ins_done     = 1'b0;
    dn_done      = 1'b0;
    in_ready_o   = 1'b0;
    min_child    = child_q;
    min_idx      = left_w[AW-1:0];

    case (state_q)
      mmch_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          last_d  = last_item_i;
          merge_d = 1'b0;
          if (size_q < SW'(MAX_ITEMS)) begin
            cur_d   = DW'(addend_i);
            pos_d   = size_q[AW-1:0];
            size_d  = size_q + SW'(1);
            state_d = mmch_pkg::ST_UP;
          end else begin
            ovf_d   = 1'b1;
            state_d = last_item_i ? mmch_pkg::ST_CHK : mmch_pkg::ST_IDLE;
          end
        end
      end

      // sift up: fetch the parent of the hole
      mmch_pkg::ST_UP: begin
        if (pos_q == '0) begin
          ram_we   = 1'b1;
          ins_done = 1'b1;
        end else begin
          ram_rd_addr = parent;
          state_d     = mmch_pkg::ST_UP_CMP;
        end
      end

      mmch_pkg::ST_UP_CMP: begin
        ram_we = 1'b1;
        if (ram_rd_data <= cur_q) begin
          ins_done = 1'b1;
        end else begin
          ram_wr_data = ram_rd_data;
          pos_d       = parent;
          state_d     = mmch_pkg::ST_UP;
        end
      end

      // merge loop check
      mmch_pkg::ST_CHK: begin
        if (size_q > SW'(1)) begin
          second_d = 1'b0;
          state_d  = mmch_pkg::ST_TAKE;
        end else begin
          state_d = mmch_pkg::ST_OUT;
        end
      end

      mmch_pkg::ST_TAKE: begin
        ram_rd_addr = '0;
        state_d     = mmch_pkg::ST_TOP;
      end

      // capture the minimum, fetch the tail entry
      mmch_pkg::ST_TOP: begin
        top_d       = ram_rd_data;
        ram_rd_addr = AW'(size_q - SW'(1));
        size_d      = size_q - SW'(1);
        state_d     = mmch_pkg::ST_LAST;
      end

      mmch_pkg::ST_LAST: begin
        cur_d   = ram_rd_data;
        pos_d   = '0;
        state_d = mmch_pkg::ST_DN;
      end

      // sift down: fetch the left child
      mmch_pkg::ST_DN: begin
        if (left_w >= size_w) begin
          ram_we  = 1'b1;
          dn_done = 1'b1;
        end else begin
          ram_rd_addr = left_w[AW-1:0];
          state_d     = mmch_pkg::ST_DN_L;
        end
      end

      mmch_pkg::ST_DN_L: begin
        child_d = ram_rd_data;
        if (right_w < size_w) begin
          ram_rd_addr = right_w[AW-1:0];
          state_d     = mmch_pkg::ST_DN_R;
        end else begin
          ram_we = 1'b1;
          if (ram_rd_data < cur_q) begin
            ram_wr_data = ram_rd_data;
            pos_d       = left_w[AW-1:0];
            state_d     = mmch_pkg::ST_DN;
          end else begin
            dn_done = 1'b1;
          end
        end
      end

      // both children known, move the smaller one up if needed
      mmch_pkg::ST_DN_R: begin
        if (ram_rd_data < child_q) begin
          min_child = ram_rd_data;
          min_idx   = right_w[AW-1:0];
        end
        ram_we = 1'b1;
        if (min_child < cur_q) begin
          ram_wr_data = min_child;
          pos_d       = min_idx;
          state_d     = mmch_pkg::ST_DN;
        end else begin
          dn_done = 1'b1;
        end
      end

      // issue the result item and clear the set
      mmch_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          total_cost_d = cost_q;
          overflow_d   = ovf_q;
          out_valid_d  = 1'b1;
          size_d       = '0;
          cost_d       = '0;
          ovf_d        = 1'b0;
          state_d      = mmch_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = mmch_pkg::ST_IDLE;
      end
    endcase

    // end of an insert
    if (ins_done) begin
      state_d = (merge_q || last_q) ? mmch_pkg::ST_CHK : mmch_pkg::ST_IDLE;
    end

    // end of a take: second minimum starts the sum insert
    if (dn_done) begin
      if (!second_q) begin
        first_d  = top_q;
        second_d = 1'b1;
        state_d  = mmch_pkg::ST_TAKE;
      end else begin
        cost_d  = cost_q + pair_sum;
        cur_d   = pair_sum;
        pos_d   = size_q[AW-1:0];
        size_d  = size_q + SW'(1);
        merge_d = 1'b1;
        state_d = mmch_pkg::ST_UP;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign total_cost_o = total_cost_q;
  assign overflow_o   = overflow_q;

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the minimum merge cost heap core.
// ----------------------------------------------------------------------------
// Addend sets are streamed into the core over a valid/ready channel. A
// scoreboard tracks each open set, works out the optimal merge cost and the
// overflow flag when the set closes, and compares every result item against
// the oldest expectation. The stimulus opens with hand-picked sets: single
// addends, zeros, all-ones, ties and alternating bit patterns. Random sets of
// mixed sizes follow under three idle mixes on the sender and receiver.
// One set past heap capacity closes the run: it fills the heap and then
// overflows it with dropped addends, the last of which carries last_item.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned MAX_N     = mmch_pkg::MAX_ITEMS_DEF;
  localparam int unsigned AW        = mmch_pkg::ADDEND_WIDTH_DEF;
  localparam int unsigned DW        = mmch_pkg::DATA_W;
  localparam int unsigned RAND_ITEMS = 150;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned TAIL_CYCLES = 50;
  localparam logic [DW-1:0] ADDEND_MASK = (DW'(1) << AW) - DW'(1);

  typedef struct packed {
    logic [DW-1:0] cost;
    logic          ovf;
  } merge_result_t;

  // tracks the open set and the merge results still owed by the core
  class merge_cost_tracker;
    logic [DW-1:0] set_values[$];
    logic          set_dropped;
    merge_result_t owed_results[$];
    int unsigned   fail_count;

    function new();
      set_dropped = 1'b0;
      fail_count  = 0;
    endfunction

    // keep the open set in ascending order
    function void put_sorted(logic [DW-1:0] v);
      int unsigned idx;
      idx = 0;
      while (idx < set_values.size() && set_values[idx] <= v) idx++;
      set_values.insert(idx, v);
    endfunction

    function void note_addend(logic [AW-1:0] addend, logic last);
      logic [DW-1:0] a;
      logic [DW-1:0] b;
      logic [DW-1:0] sum;
      logic [DW-1:0] cost;
      merge_result_t res;
      if (set_values.size() < MAX_N) begin
        put_sorted(DW'(addend) & ADDEND_MASK);
      end else begin
        set_dropped = 1'b1;
      end
      if (!last) return;
      // merge the two smallest until one value is left
      cost = '0;
      while (set_values.size() > 1) begin
        a    = set_values.pop_front();
        b    = set_values.pop_front();
        sum  = a + b;
        cost = cost + sum;
        put_sorted(sum);
      end
      res.cost = cost;
      res.ovf  = set_dropped;
      owed_results.push_back(res);
      set_values.delete();
      set_dropped = 1'b0;
    endfunction

    function void check_result(logic [DW-1:0] cost, logic ovf);
      merge_result_t res;
      if (owed_results.size() == 0) begin
        $error("result item with none expected: total_cost %0h overflow %0b", cost, ovf);
        fail_count++;
        return;
      end
      res = owed_results.pop_front();
      if (cost !== res.cost) begin
        $error("total_cost: expected %0h, got %0h", res.cost, cost);
        fail_count++;
      end
      if (ovf !== res.ovf) begin
        $error("overflow: expected %0b, got %0b", res.ovf, ovf);
        fail_count++;
      end
    endfunction

    function bit busy();
      return owed_results.size() != 0;
    endfunction
  endclass

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid    = 1'b0;
  logic           in_ready;
  logic [AW-1:0]  addend      = '0;
  logic           last_item   = 1'b0;
  logic           out_valid;
  logic           out_ready   = 1'b0;
  logic [DW-1:0]  total_cost;
  logic           overflow;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_cnt     = 0;

  merge_cost_tracker tracker = new();

  min_merge_cost_heap_core #(
    .MAX_ITEMS    (MAX_N),
    .ADDEND_WIDTH (AW)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .addend_i     (addend),
    .last_item_i  (last_item),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .total_cost_o (total_cost),
    .overflow_o   (overflow)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // cycle counter and run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // result side: check accepted items, random back-pressure
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      tracker.check_result(total_cost, overflow);
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one addend item, with random idle cycles ahead of it
  task automatic send_item(input logic [AW-1:0] value, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    addend    <= value;
    last_item <= last;
    do @(posedge clk_i); while (!in_ready);
    tracker.note_addend(value, last);
  endtask

  // hold off the sender until every owed result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (tracker.busy());
  endtask

  function automatic logic [AW-1:0] pick_addend();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return AW'($urandom_range(15));
      3:       return AW'(1) << $urandom_range(AW - 1);
      4:       return ~(AW'(1) << $urandom_range(AW - 1));
      default: return AW'($urandom);
    endcase
  endfunction

  task automatic send_set(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      send_item(pick_addend(), i == n - 1);
    end
  endtask

  // mostly short sets, some medium, a few long
  task automatic random_sets(input int unsigned count);
    int unsigned sent;
    int unsigned sel;
    int unsigned n;
    sent = 0;
    while (sent < count) begin
      sel = $urandom_range(99);
      if (sel < 10)      n = 1;
      else if (sel < 80) n = $urandom_range(2, 12);
      else if (sel < 97) n = $urandom_range(13, 60);
      else               n = $urandom_range(61, 200);
      send_set(n);
      sent += n;
    end
  endtask

  // stimulus
  initial begin
    send_idle_pct = 9;
    recv_idle_pct = 79;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single addends give zero cost
    send_item('0, 1'b1);
    send_item('1, 1'b1);
    // zeros and all-ones pairs
    send_item('0, 1'b0);
    send_item('0, 1'b1);
    send_item('1, 1'b0);
    send_item('1, 1'b1);
    // four all-ones addends
    repeat (3) send_item('1, 1'b0);
    send_item('1, 1'b1);
    // ties
    repeat (2) send_item(AW'(5), 1'b0);
    send_item(AW'(5), 1'b1);
    // alternating and single-bit patterns
    send_item({(AW/2){2'b10}}, 1'b0);
    send_item({(AW/2){2'b01}}, 1'b0);
    send_item(AW'(1), 1'b0);
    send_item(AW'(1) << (AW - 1), 1'b1);

    random_sets(RAND_ITEMS);
    drain();

    send_idle_pct = 79;
    recv_idle_pct = 9;
    random_sets(RAND_ITEMS);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_sets(RAND_ITEMS);

    // heap filled, then overflow; a dropped item closes the set
    send_set(MAX_N + 2);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
